### rtl/srd_pkg.sv
package srd_pkg;

  function automatic logic signed [63:0] sat_w(input logic signed [63:0] v, input int w);
    logic signed [63:0] qmax;
    logic signed [63:0] qmin;
    qmax = (64'sd1 <<< (w - 1)) - 64'sd1;
    qmin = -qmax - 64'sd1;
    if (v > qmax) begin
      return qmax;
    end else if (v < qmin) begin
      return qmin;
    end
    return v;
  endfunction

  function automatic logic signed [63:0] mulq_w(input logic signed [63:0] a,
                                                 input logic signed [63:0] b,
                                                 input int w, input int f);
    logic                neg;
    logic        [63:0]  ma;
    logic        [63:0]  mb;
    logic        [127:0] p;
    logic        [127:0] m;
    logic signed [63:0]  qmax;
    neg  = (a < 0) != (b < 0);
    ma   = (a < 0) ? 64'(-a) : 64'(a);
    mb   = (b < 0) ? 64'(-b) : 64'(b);
    p    = 128'(ma) * 128'(mb) + (128'd1 << (f - 1));
    m    = p >> f;
    qmax = (64'sd1 <<< (w - 1)) - 64'sd1;
    if (neg) begin
      if (m > 128'(qmax) + 128'd1) begin
        return -qmax - 64'sd1;
      end
      return -$signed(64'(m));
    end
    if (m > 128'(qmax)) begin
      return qmax;
    end
    return $signed(64'(m));
  endfunction

endpackage

### rtl/srd_front.sv
module srd_front
  import srd_pkg::*;
#(
  parameter int W = 20,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] inc_x,
  input  logic signed [W-1:0] inc_y,
  input  logic signed [W-1:0] inc_z,
  input  logic signed [W-1:0] norm_x,
  input  logic signed [W-1:0] norm_y,
  input  logic signed [W-1:0] norm_z,
  input  logic        [W-2:0] index_ratio,
  output logic signed [W-1:0] perp_x,
  output logic signed [W-1:0] perp_y,
  output logic signed [W-1:0] perp_z,
  output logic signed [W-1:0] nrm_x,
  output logic signed [W-1:0] nrm_y,
  output logic signed [W-1:0] nrm_z
);

  localparam logic signed [63:0] QOne = 64'sd1 <<< F;

  logic signed [W-1:0] p1_x, p1_y, p1_z;
  logic signed [W-1:0] i1_x, i1_y, i1_z, n1_x, n1_y, n1_z;
  logic        [W-2:0] r1;
  logic signed [W-1:0] c2;
  logic signed [W-1:0] i2_x, i2_y, i2_z, n2_x, n2_y, n2_z;
  logic        [W-2:0] r2;
  logic signed [W-1:0] s3_x, s3_y, s3_z, n3_x, n3_y, n3_z;
  logic        [W-2:0] r3;
  logic signed [63:0]  c_next;

  always_comb begin
    c_next = -sat_w(64'(p1_x) + 64'(p1_y) + 64'(p1_z), W);
    if (c_next > QOne) begin
      c_next = QOne;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_x <= W'(mulq_w(64'(inc_x), 64'(norm_x), W, F));
      p1_y <= W'(mulq_w(64'(inc_y), 64'(norm_y), W, F));
      p1_z <= W'(mulq_w(64'(inc_z), 64'(norm_z), W, F));
      i1_x <= inc_x; i1_y <= inc_y; i1_z <= inc_z;
      n1_x <= norm_x; n1_y <= norm_y; n1_z <= norm_z;
      r1   <= index_ratio;
      c2   <= W'(c_next);
      i2_x <= i1_x; i2_y <= i1_y; i2_z <= i1_z;
      n2_x <= n1_x; n2_y <= n1_y; n2_z <= n1_z;
      r2   <= r1;
      s3_x <= W'(sat_w(64'(i2_x) + mulq_w(64'(c2), 64'(n2_x), W, F), W));
      s3_y <= W'(sat_w(64'(i2_y) + mulq_w(64'(c2), 64'(n2_y), W, F), W));
      s3_z <= W'(sat_w(64'(i2_z) + mulq_w(64'(c2), 64'(n2_z), W, F), W));
      n3_x <= n2_x; n3_y <= n2_y; n3_z <= n2_z;
      r3   <= r2;
      perp_x <= W'(mulq_w(64'(r3), 64'(s3_x), W, F));
      perp_y <= W'(mulq_w(64'(r3), 64'(s3_y), W, F));
      perp_z <= W'(mulq_w(64'(r3), 64'(s3_z), W, F));
      nrm_x <= n3_x; nrm_y <= n3_y; nrm_z <= n3_z;
    end
  end

endmodule

### rtl/srd_root.sv
module srd_root
  import srd_pkg::*;
#(
  parameter int W = 20,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] perp_x,
  input  logic signed [W-1:0] perp_y,
  input  logic signed [W-1:0] perp_z,
  input  logic signed [W-1:0] nrm_x,
  input  logic signed [W-1:0] nrm_y,
  input  logic signed [W-1:0] nrm_z,
  output logic signed [W-1:0] out_x,
  output logic signed [W-1:0] out_y,
  output logic signed [W-1:0] out_z
);

  localparam int RB = (W + F + 1) / 2 + 1;
  localparam int TB = 2 * RB;
  localparam int NS = RB;

  logic signed [W-1:0] q_x, q_y, q_z;
  logic signed [W-1:0] pa_x, pa_y, pa_z, na_x, na_y, na_z;
  logic        [W-1:0] mag;
  logic signed [W-1:0] pb_x, pb_y, pb_z, nb_x, nb_y, nb_z;
  logic signed [63:0]  sq;
  logic signed [63:0]  d;

  logic [TB-1:0]       rad [NS+1];
  logic [RB-1:0]       rt  [NS+1];
  logic signed [W-1:0] pp_x [NS+1], pp_y [NS+1], pp_z [NS+1];
  logic signed [W-1:0] nn_x [NS+1], nn_y [NS+1], nn_z [NS+1];

  logic signed [W-1:0] r;

  always_comb begin
    sq = sat_w(64'(q_x) + 64'(q_y) + 64'(q_z), W);
    d  = sat_w((64'sd1 <<< F) - sq, W);
  end

  always_comb begin
    rad[0] = TB'(mag) << F;
    rt[0]  = '0;
    pp_x[0] = pb_x; pp_y[0] = pb_y; pp_z[0] = pb_z;
    nn_x[0] = nb_x; nn_y[0] = nb_y; nn_z[0] = nb_z;
  end

  for (genvar k = 0; k < NS; k++) begin : g_step
    logic [RB-1:0] cand;
    logic [TB-1:0] csq;
    assign cand = rt[k] | (RB'(1) << (NS - 1 - k));
    assign csq  = TB'(cand) * TB'(cand);
    always_ff @(posedge clk) begin
      if (en) begin
        rad[k+1] <= rad[k];
        rt[k+1]  <= (csq <= rad[k]) ? cand : rt[k];
        pp_x[k+1] <= pp_x[k]; pp_y[k+1] <= pp_y[k]; pp_z[k+1] <= pp_z[k];
        nn_x[k+1] <= nn_x[k]; nn_y[k+1] <= nn_y[k]; nn_z[k+1] <= nn_z[k];
      end
    end
  end

  assign r = W'(sat_w(64'(rt[NS]), W));

  always_ff @(posedge clk) begin
    if (en) begin
      q_x <= W'(mulq_w(64'(perp_x), 64'(perp_x), W, F));
      q_y <= W'(mulq_w(64'(perp_y), 64'(perp_y), W, F));
      q_z <= W'(mulq_w(64'(perp_z), 64'(perp_z), W, F));
      pa_x <= perp_x; pa_y <= perp_y; pa_z <= perp_z;
      na_x <= nrm_x; na_y <= nrm_y; na_z <= nrm_z;
      mag  <= (d < 0) ? W'(-d) : W'(d);
      pb_x <= pa_x; pb_y <= pa_y; pb_z <= pa_z;
      nb_x <= na_x; nb_y <= na_y; nb_z <= na_z;
      out_x <= W'(sat_w(64'(pp_x[NS]) + sat_w(-mulq_w(64'(r), 64'(nn_x[NS]), W, F), W), W));
      out_y <= W'(sat_w(64'(pp_y[NS]) + sat_w(-mulq_w(64'(r), 64'(nn_y[NS]), W, F), W), W));
      out_z <= W'(sat_w(64'(pp_z[NS]) + sat_w(-mulq_w(64'(r), 64'(nn_z[NS]), W, F), W), W));
    end
  end

endmodule

### rtl/snell_refraction_direction.sv
// The restoring square root, one result bit per stage, sets most of the pipeline depth.
// Throughput: one transaction per cycle; a stalled output holds every stage.
// Reset: rst clears the stage valid bits only; data registers are not reset.
module snell_refraction_direction #(
  parameter int FRAC_BITS = 16,
  parameter int INT_BITS  = 3
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [INT_BITS+FRAC_BITS:0]     inc_x,
  input  logic signed [INT_BITS+FRAC_BITS:0]     inc_y,
  input  logic signed [INT_BITS+FRAC_BITS:0]     inc_z,
  input  logic signed [INT_BITS+FRAC_BITS:0]     norm_x,
  input  logic signed [INT_BITS+FRAC_BITS:0]     norm_y,
  input  logic signed [INT_BITS+FRAC_BITS:0]     norm_z,
  input  logic        [INT_BITS+FRAC_BITS-1:0]   index_ratio,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [INT_BITS+FRAC_BITS:0]     out_x,
  output logic signed [INT_BITS+FRAC_BITS:0]     out_y,
  output logic signed [INT_BITS+FRAC_BITS:0]     out_z
);

  localparam int W     = 1 + INT_BITS + FRAC_BITS;
  localparam int RB    = (W + FRAC_BITS + 1) / 2 + 1;
  localparam int DEPTH = 4 + 3 + RB;

  logic                      en;
  logic [DEPTH-1:0]          vld;
  logic signed [W-1:0]       perp_x, perp_y, perp_z, nrm_x, nrm_y, nrm_z;

  assign en        = !vld[DEPTH-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  srd_front #(.W(W), .F(FRAC_BITS)) u_front (
    .clk, .en, .inc_x, .inc_y, .inc_z, .norm_x, .norm_y, .norm_z, .index_ratio,
    .perp_x, .perp_y, .perp_z, .nrm_x, .nrm_y, .nrm_z
  );

  srd_root #(.W(W), .F(FRAC_BITS)) u_root (
    .clk, .en, .perp_x, .perp_y, .perp_z, .nrm_x, .nrm_y, .nrm_z,
    .out_x, .out_y, .out_z
  );

endmodule

### rtl/srd_checker.sv
module srd_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  a_stall_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken during stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind snell_refraction_direction srd_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready
);
